// ===== rtl/multi_algorithm_string_hash_top_assert.svh =====
// ----------------------------------------------------------------------------
// String hash assertion macros
// Shared property forms for the string hash block, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_ALGORITHM_STRING_HASH_TOP_ASSERT_SVH
`define MULTI_ALGORITHM_STRING_HASH_TOP_ASSERT_SVH

// Same-cycle implication
`define MASH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define MASH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mash_pkg.sv =====
// ----------------------------------------------------------------------------
// String hash package
// Types, mode codes, constants and helper functions of the string hash block.
// ----------------------------------------------------------------------------
package mash_pkg;

    typedef logic [31:0] t_hash;
    typedef logic [3:0]  t_mode;
    typedef logic [6:0]  t_len;
    typedef logic [7:0]  t_char;
    typedef logic [0:0]  t_cfg_idx;
    typedef logic [6:0]  t_cfg_data;

    // Hash mode codes
    localparam t_mode MODE_RS   = 4'd0;
    localparam t_mode MODE_JS   = 4'd1;
    localparam t_mode MODE_PJW  = 4'd2;
    localparam t_mode MODE_ELF  = 4'd3;
    localparam t_mode MODE_BKDR = 4'd4;
    localparam t_mode MODE_SDBM = 4'd5;
    localparam t_mode MODE_DJB  = 4'd6;
    localparam t_mode MODE_DEK  = 4'd7;
    localparam t_mode MODE_AP   = 4'd8;

    // Register indexes
    localparam t_cfg_idx REG_ALGORITHM   = 1'b0;
    localparam t_cfg_idx REG_WORD_LENGTH = 1'b1;

    localparam t_len  MAX_WORD_LENGTH = 7'd64;
    localparam t_len  WORD_LENGTH_RST = 7'd10;

    localparam t_hash RS_B     = 32'd378551;
    localparam t_hash RS_A0    = 32'd63689;
    localparam t_hash JS_SEED  = 32'd1315423911;
    localparam t_hash ELF_HIGH = 32'hF000_0000;
    localparam t_hash DJB_SEED = 32'd5381;
    localparam t_hash AP_SEED  = 32'hAAAA_AAAA;

    // Control beat from the top level to the absorb step
    typedef struct packed {
        t_mode mode;
        logic  odd;
    } t_absorb_ctl;

    // Undefined codes fall back to RS
    function automatic t_mode eff_mode(input t_mode alg);
        eff_mode = (alg > MODE_AP) ? MODE_RS : alg;
    endfunction

    // Clamp word length to 1..MAX_WORD_LENGTH
    function automatic t_len eff_len(input t_len len);
        if (len == 7'd0) begin
            eff_len = 7'd1;
        end else if (len > MAX_WORD_LENGTH) begin
            eff_len = MAX_WORD_LENGTH;
        end else begin
            eff_len = len;
        end
    endfunction

    // Seed of a mode; DEK seeds with the effective length
    function automatic t_hash mode_seed(input t_mode mode, input t_len len);
        unique case (mode)
            MODE_JS:  mode_seed = JS_SEED;
            MODE_DJB: mode_seed = DJB_SEED;
            MODE_DEK: mode_seed = {25'd0, len};
            MODE_AP:  mode_seed = AP_SEED;
            default:  mode_seed = '0;
        endcase
    endfunction

endpackage

// ===== rtl/mash_absorb.sv =====
// ----------------------------------------------------------------------------
// String hash absorb step
// Folds one character into the running hash under the selected mode and
// advances the RS multiplier in RS mode.
// ----------------------------------------------------------------------------
module mash_absorb (
    input  mash_pkg::t_absorb_ctl i_ctl,
    input  mash_pkg::t_hash       i_hash,
    input  mash_pkg::t_hash       i_rs_mult,
    input  mash_pkg::t_char       i_char,
    output mash_pkg::t_hash       o_hash,
    output mash_pkg::t_hash       o_rs_mult
);
    import mash_pkg::*;

    t_hash c32;
    t_hash elf_sum;
    t_hash elf_top;
    t_hash ap_prod;
    t_hash rs_prod;

    assign c32 = {24'd0, i_char};

    // ELF/PJW intermediate
    assign elf_sum = (i_hash << 4) + c32;
    assign elf_top = elf_sum & ELF_HIGH;

    // Narrow product for AP even positions, full product for RS
    assign ap_prod = c32 * (i_hash >> 3);
    assign rs_prod = i_hash * i_rs_mult;

    // Advance the RS multiplier only in RS mode
    assign o_rs_mult = (i_ctl.mode == MODE_RS) ? (i_rs_mult * RS_B) : i_rs_mult;

    // Select the per-mode update
    always_comb begin
        unique case (i_ctl.mode)
            MODE_JS:   o_hash = i_hash ^ ((i_hash << 5) + c32 + (i_hash >> 2));
            MODE_PJW,
            MODE_ELF:  o_hash = (elf_sum ^ (elf_top >> 24)) & ~elf_top;
            MODE_BKDR: o_hash = (i_hash << 7) + (i_hash << 1) + i_hash + c32;
            MODE_SDBM: o_hash = c32 + (i_hash << 6) + (i_hash << 16) - i_hash;
            MODE_DJB:  o_hash = (i_hash << 5) + i_hash + c32;
            MODE_DEK:  o_hash = ((i_hash << 5) ^ (i_hash >> 27)) ^ c32;
            MODE_AP: begin
                if (i_ctl.odd) begin
                    o_hash = i_hash ^ ~((i_hash << 11) + (c32 ^ (i_hash >> 5)));
                end else begin
                    o_hash = i_hash ^ ((i_hash << 7) ^ ap_prod);
                end
            end
            default:   o_hash = rs_prod + c32;
        endcase
    end

endmodule

// ===== rtl/multi_algorithm_string_hash_top.sv =====
// ----------------------------------------------------------------------------
// Multi-algorithm string hash
// Byte-stream hash engine with RS, JS, PJW, ELF, BKDR, SDBM, DJB, DEK and AP.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one character byte per beat.
//   Output channel (o_valid/i_ready) carries one 32-bit hash per word.
//   A word is word_length bytes (0 counts as 1, above 64 clamps to 64).
//   The block takes one byte every cycle but while a word-ending byte waits.
//   The running hash, RS multiplier and byte position update on each accept.
//   The hash of a word shows on the output in the cycle after its last byte
//   is accepted, held in the output register.
//   While a result waits, bytes that do not end a word are still taken; a
//   byte that ends a word waits until the output register is taken or empty.
//   Any register write drops the word in progress and restarts from the
//   seed of the selected mode. Write registers only while idle.
//   Reset selects RS, a word length of 10, and clears the output valid.
// ----------------------------------------------------------------------------
module multi_algorithm_string_hash_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  mash_pkg::t_char      i_char_byte,
    output logic                 o_valid,
    input  logic                 i_ready,
    output mash_pkg::t_hash      o_hash_value,
    input  logic                 i_cfg_we,
    input  mash_pkg::t_cfg_idx   i_cfg_index,
    input  mash_pkg::t_cfg_data  i_cfg_data
);
    import mash_pkg::*;

    t_mode       r_algorithm;
    t_len        r_word_length;
    t_hash       r_hash;
    t_hash       r_rs_mult;
    t_len        r_pos;
    logic        r_out_valid;
    t_hash       r_hash_out;

    t_mode       n_algorithm;
    t_len        n_word_length;
    t_mode       mode;
    t_len        len;
    logic        last;
    logic        accept;
    t_absorb_ctl ctl;
    t_hash       step_hash;
    t_hash       step_mult;

    assign mode = eff_mode(r_algorithm);
    assign len  = eff_len(r_word_length);

    // Byte ends the word
    assign last = ({1'b0, r_pos} + 8'd1) >= {1'b0, len};

    // Hold a word-ending beat only while an untaken result sits in the register
    assign o_ready = !r_out_valid || i_ready || !last;
    assign accept  = i_valid && o_ready;

    assign ctl.mode = mode;
    assign ctl.odd  = r_pos[0];

    mash_absorb u_absorb (
        .i_ctl     (ctl),
        .i_hash    (r_hash),
        .i_rs_mult (r_rs_mult),
        .i_char    (i_char_byte),
        .o_hash    (step_hash),
        .o_rs_mult (step_mult)
    );

    // Decode configuration writes
    always_comb begin
        n_algorithm   = r_algorithm;
        n_word_length = r_word_length;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ALGORITHM:   n_algorithm   = i_cfg_data[3:0];
                REG_WORD_LENGTH: n_word_length = i_cfg_data;
                default:         n_algorithm   = r_algorithm;
            endcase
        end
    end

    // Configuration and hash state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_algorithm   <= MODE_RS;
            r_word_length <= WORD_LENGTH_RST;
            r_hash        <= mode_seed(MODE_RS, eff_len(WORD_LENGTH_RST));
            r_rs_mult     <= RS_A0;
            r_pos         <= '0;
        end else if (i_cfg_we) begin
            r_algorithm   <= n_algorithm;
            r_word_length <= n_word_length;
            r_hash        <= mode_seed(eff_mode(n_algorithm), eff_len(n_word_length));
            r_rs_mult     <= RS_A0;
            r_pos         <= '0;
        end else if (accept) begin
            if (last) begin
                r_hash    <= mode_seed(mode, len);
                r_rs_mult <= RS_A0;
                r_pos     <= '0;
            end else begin
                r_hash    <= step_hash;
                r_rs_mult <= step_mult;
                r_pos     <= r_pos + 7'd1;
            end
        end
    end

    // Output register: load on a word-ending beat, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && last) begin
            r_hash_out <= step_hash;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hash_value = r_hash_out;

    // Checks
`include "multi_algorithm_string_hash_top_assert.svh"

    `MASH_ASSERT_NOW(a_pos_in_word, 1'b1, r_pos < len, "byte position past word end")
    `MASH_ASSERT_NOW(a_no_overwrite, r_out_valid && !i_ready, !(accept && last),
        "pending result overwritten")
    `MASH_ASSERT_NEXT(a_result_follows, accept && last, o_valid,
        "word end without result")
    `MASH_ASSERT_NEXT(a_pos_advance, accept && !last && !i_cfg_we,
        r_pos == $past(r_pos) + 7'd1, "byte position did not advance")
    `MASH_ASSERT_NEXT(a_cfg_restart, i_cfg_we, r_pos == '0 && r_rs_mult == RS_A0,
        "register write did not restart the word")

endmodule
